// File: hdl/ptsp_pkg.sv
// shared types, constants and helpers for the powertrain signal plausibility block
package ptsp_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_SPEED_MAX         = 3'd0,
    CFG_SPEED_JUMP_LIMIT  = 3'd1,
    CFG_SPEED_JITTER_STEP = 3'd2,
    CFG_BRAKE_JITTER_STEP = 3'd3,
    CFG_RECOVERY_CYCLES   = 3'd4
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned FaultW   = 14;

  // register reset values
  localparam logic [14:0] SpeedMaxRst        = 15'd25000;
  localparam logic [14:0] SpeedJumpLimitRst  = 15'd2000;
  localparam logic [14:0] SpeedJitterStepRst = 15'd200;
  localparam logic [14:0] BrakeJitterStepRst = 15'd500;
  localparam logic [15:0] RecoveryCyclesRst  = 16'd10;

  // fixed thresholds
  localparam logic [14:0] SpeedCreep    = 15'd500;
  localparam logic [15:0] SpeedSurge    = 16'd1000;
  localparam logic [14:0] BrakeFull     = 15'd10000;
  localparam logic [14:0] BrakeHard     = 15'd9500;
  localparam logic [7:0]  ReversalLimit = 8'd6;
  localparam logic [7:0]  ChangeLimit   = 8'd5;
  localparam logic [7:0]  CountMax      = 8'd255;
  localparam logic [7:0]  IgnOff        = 8'd0;
  localparam logic [7:0]  IgnOn         = 8'd2;
  localparam logic [7:0]  IgnStart      = 8'd3;

  // fault word bit positions
  localparam int unsigned FltSpeedBad    = 0;
  localparam int unsigned FltSpeedRange  = 1;
  localparam int unsigned FltSpeedFrozen = 2;
  localparam int unsigned FltSpeedJump   = 3;
  localparam int unsigned FltSpeedJitter = 4;
  localparam int unsigned FltSpeedIgnOff = 5;
  localparam int unsigned FltIgnRange    = 6;
  localparam int unsigned FltIgnChatter  = 7;
  localparam int unsigned FltIgnSkip     = 8;
  localparam int unsigned FltBrakeBad    = 9;
  localparam int unsigned FltBrakeRange  = 10;
  localparam int unsigned FltBrakeJitter = 11;
  localparam int unsigned FltBrakeSurge  = 12;
  localparam int unsigned FltRecovery    = 13;

  // delta tracker status
  typedef struct packed {
    logic signed [16:0] dlt;
    logic               dlt_undef;
    logic               nojit;
  } jit_sts_t;

  // ignition checker status
  typedef struct packed {
    logic in_range;
    logic nojit;
    logic skip;
  } ign_sts_t;

  // saturating increment of an 8-bit counter
  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    return (c < CountMax) ? c + 8'd1 : CountMax;
  endfunction

  // magnitude of a 17-bit signed delta
  function automatic logic [16:0] mag17(input logic signed [16:0] v);
    return v[16] ? 17'(-v) : 17'(v);
  endfunction

endpackage

// File: hdl/ptsp_jitter.sv
// sample history, delta and reversal jitter counter for one signal
module ptsp_jitter (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic signed [15:0]    sample_i,
  input  logic                  bad_i,
  input  logic [14:0]           step_i,
  output ptsp_pkg::jit_sts_t    sts_o
);
  import ptsp_pkg::*;

  logic signed [15:0] last_q;
  logic               last_bad_q;
  logic signed [16:0] dlt_q, dlt_d;
  logic               dlt_undef_q, dlt_undef_d;
  logic [7:0]         rev_q, rev_d;
  logic               upd;
  logic               opposite;

  // current delta, undefined when either sample is bad
  assign dlt_undef_d = bad_i | last_bad_q;
  assign dlt_d = dlt_undef_d ? 17'sd0 : (17'(sample_i) - 17'(last_q));

  // reversal counter
  always_comb begin
    upd = !bad_i && !dlt_undef_d && !dlt_undef_q &&
          (mag17(dlt_d) > {2'b00, step_i}) && (mag17(dlt_q) > {2'b00, step_i});
    opposite = dlt_d[16] ^ dlt_q[16];
    rev_d = rev_q;
    if (upd) begin
      rev_d = opposite ? sat_inc(rev_q) : 8'd0;
    end
  end

  assign sts_o.dlt       = dlt_d;
  assign sts_o.dlt_undef = dlt_undef_d;
  assign sts_o.nojit     = rev_d < ReversalLimit;

  // history update on each processed transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= '0;
      last_bad_q  <= 1'b0;
      dlt_q       <= '0;
      dlt_undef_q <= 1'b0;
      rev_q       <= '0;
    end else if (en_i) begin
      last_q      <= sample_i;
      last_bad_q  <= bad_i;
      dlt_q       <= dlt_d;
      dlt_undef_q <= dlt_undef_d;
      rev_q       <= rev_d;
    end
  end

endmodule

// File: hdl/ptsp_ignition.sv
// ignition code range, chatter and skipped-accessory checks
module ptsp_ignition (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [7:0]         ign_i,
  output ptsp_pkg::ign_sts_t sts_o
);
  import ptsp_pkg::*;

  logic [7:0] last_q;
  logic [7:0] chg_q, chg_d;

  // change counter clears on a steady code
  assign chg_d = (ign_i != last_q) ? sat_inc(chg_q) : 8'd0;

  assign sts_o.in_range = ign_i <= IgnStart;
  assign sts_o.nojit    = chg_d < ChangeLimit;
  assign sts_o.skip     = (ign_i <= IgnStart) && (last_q == IgnOff) && (ign_i >= IgnOn);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= IgnOff;
      chg_q  <= '0;
    end else if (en_i) begin
      last_q <= ign_i;
      chg_q  <= chg_d;
    end
  end

endmodule

// File: hdl/powertrain_signal_plausibility.sv
// top level of the powertrain signal plausibility checker
// Takes one sample set (speed, ignition, brake) per transfer and returns one result
// per sample set: a 14-bit fault word, per-signal valid flags and a composite valid
// that returns only after recovery_cycles good samples in a row. A sample passes an
// input register and the check logic into a result register. With the result side
// ready, one sample set is taken every cycle. A result that waits lets one more sample
// set into the input register, then input transfers stall until the result is taken.
// Configuration writes are to be made only while no sample set is in flight.
module powertrain_signal_plausibility (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [ptsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ptsp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // sample stream
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // speed[15:0], speed_bad[16], ignition[24:17], brake[40:25], brake_bad[41], zero fill
  input  logic [ptsp_pkg::InDataW-1:0]   s_axis_tdata_i,
  // result stream
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // fault_code[13:0], speed_ok[14], ignition_ok[15], brake_ok[16], composite_ok[17],
  // zero fill
  output logic [ptsp_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import ptsp_pkg::*;

  // configuration registers
  logic [14:0] speed_max_q;
  logic [14:0] speed_jump_limit_q;
  logic [14:0] speed_jitter_step_q;
  logic [14:0] brake_jitter_step_q;
  logic [15:0] recovery_cycles_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_max_q         <= SpeedMaxRst;
      speed_jump_limit_q  <= SpeedJumpLimitRst;
      speed_jitter_step_q <= SpeedJitterStepRst;
      brake_jitter_step_q <= BrakeJitterStepRst;
      recovery_cycles_q   <= RecoveryCyclesRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_SPEED_MAX:         speed_max_q         <= cfg_wdata_i[14:0];
        CFG_SPEED_JUMP_LIMIT:  speed_jump_limit_q  <= cfg_wdata_i[14:0];
        CFG_SPEED_JITTER_STEP: speed_jitter_step_q <= cfg_wdata_i[14:0];
        CFG_BRAKE_JITTER_STEP: brake_jitter_step_q <= cfg_wdata_i[14:0];
        CFG_RECOVERY_CYCLES:   recovery_cycles_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register and stage advance
  logic                in_vld_q;
  logic [InDataW-1:0]  in_data_q;
  logic                out_vld_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;
  logic                advance;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_data_q <= s_axis_tdata_i;
    end
  end

  // unpack the registered sample set
  logic signed [15:0] spd;
  logic               spd_bad;
  logic [7:0]         ign;
  logic signed [15:0] brk;
  logic               brk_bad;

  assign spd     = in_data_q[15:0];
  assign spd_bad = in_data_q[16];
  assign ign     = in_data_q[24:17];
  assign brk     = in_data_q[40:25];
  assign brk_bad = in_data_q[41];

  // per-signal history units
  jit_sts_t spd_sts;
  jit_sts_t brk_sts;
  ign_sts_t ign_sts;

  ptsp_jitter u_speed_jit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (spd),
    .bad_i    (spd_bad),
    .step_i   (speed_jitter_step_q),
    .sts_o    (spd_sts)
  );

  ptsp_jitter u_brake_jit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .sample_i (brk),
    .bad_i    (brk_bad),
    .step_i   (brake_jitter_step_q),
    .sts_o    (brk_sts)
  );

  ptsp_ignition u_ign (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (advance),
    .ign_i  (ign),
    .sts_o  (ign_sts)
  );

  // speed, brake and cross checks
  logic        spd_range, spd_nojump, speed_ok;
  logic        brk_range, brake_ok, ignition_ok;
  logic        raw_ok, composite_ok;
  logic [15:0] rec_q, rec_d;
  logic [FaultW-1:0] fault;

  always_comb begin
    spd_range  = !spd_bad && !spd[15] && (spd[14:0] <= speed_max_q);
    spd_nojump = spd_bad ||
                 (!spd_sts.dlt_undef && (mag17(spd_sts.dlt) <= {2'b00, speed_jump_limit_q}));
    speed_ok   = spd_range && spd_nojump && spd_sts.nojit;

    brk_range  = !brk_bad && !brk[15] && (brk[14:0] <= BrakeFull);
    brake_ok   = brk_range && brk_sts.nojit;

    ignition_ok = ign_sts.in_range && ign_sts.nojit;

    // recovery gate
    raw_ok = speed_ok && ignition_ok && brake_ok;
    rec_d  = 16'd0;
    if (raw_ok) begin
      rec_d = (rec_q < recovery_cycles_q) ? rec_q + 16'd1 : rec_q;
    end
    composite_ok = rec_d >= recovery_cycles_q;

    fault                 = '0;
    fault[FltSpeedBad]    = spd_bad;
    fault[FltSpeedRange]  = !spd_bad && !spd_range;
    fault[FltSpeedFrozen] = 1'b0;
    fault[FltSpeedJump]   = !spd_nojump;
    fault[FltSpeedJitter] = !spd_sts.nojit;
    fault[FltSpeedIgnOff] = !spd_bad && !spd[15] && (spd[14:0] > SpeedCreep) && (ign == IgnOff);
    fault[FltIgnRange]    = !ign_sts.in_range;
    fault[FltIgnChatter]  = !ign_sts.nojit;
    fault[FltIgnSkip]     = ign_sts.skip;
    fault[FltBrakeBad]    = brk_bad;
    fault[FltBrakeRange]  = !brk_bad && !brk_range;
    fault[FltBrakeJitter] = !brk_sts.nojit;
    fault[FltBrakeSurge]  = !brk_bad && !brk[15] && (brk[14:0] >= BrakeHard) &&
                            !spd_sts.dlt_undef && !spd_sts.dlt[16] &&
                            (spd_sts.dlt[15:0] > SpeedSurge);
    fault[FltRecovery]    = raw_ok && !composite_ok;

    out_data_d = {6'd0, composite_ok, brake_ok, ignition_ok, speed_ok, fault};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= RecoveryCyclesRst;
    end else if (advance) begin
      rec_q <= rec_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

  // a composite pass never carries the recovery fault
  a_comp_no_rec_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[17] |-> !out_data_q[FltRecovery])
    else $error("composite valid with recovery fault");

  // speed valid excludes the bad, range, jump and jitter speed faults
  a_speed_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[14] |->
      !out_data_q[FltSpeedBad] && !out_data_q[FltSpeedRange] &&
      !out_data_q[FltSpeedJump] && !out_data_q[FltSpeedJitter])
    else $error("speed valid with speed fault");

  // brake valid excludes the bad, range and jitter brake faults
  a_brake_ok_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_data_q[16] |->
      !out_data_q[FltBrakeBad] && !out_data_q[FltBrakeRange] &&
      !out_data_q[FltBrakeJitter])
    else $error("brake valid with brake fault");

  // a held sample set stays in the input register until it advances
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !advance |=> in_vld_q && $stable(in_data_q))
    else $error("input register lost a pending sample set");

  // an advance always produces a pending result
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advance without result");

endmodule

// File: tb/powertrain_signal_plausibility_test.sv
// self-checking stream testbench for the powertrain signal plausibility checker
module powertrain_signal_plausibility_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptsp_pkg::*;

  // fixed thresholds of the checks, kept apart from the design's own copies
  localparam int CreepSpeed   = 500;
  localparam int SurgeDelta   = 1000;
  localparam int PedalFull    = 10000;
  localparam int PedalHard    = 9500;
  localparam int ReversalTrip = 6;
  localparam int ChangeTrip   = 5;
  localparam logic [7:0] KeyAcc = 8'd1;
  localparam int StallLimit   = 1000;
  localparam int ReportCap    = 50;

  // one sample set as it travels on the input stream
  typedef struct {
    logic signed [15:0] speed;
    logic               speed_bad;
    logic [7:0]         ignition;
    logic signed [15:0] brake;
    logic               brake_bad;
  } sample_t;

  // one verdict, laid out as the low bits of the result word
  typedef struct packed {
    logic        composite_ok;
    logic        brake_ok;
    logic        ignition_ok;
    logic        speed_ok;
    logic [13:0] fault;
  } verdict_t;

  // stimulus shapes
  typedef enum {
    DRV_CRUISE, DRV_SPEED_SHAKE, DRV_BRAKE_SHAKE, DRV_IGN_CHATTER,
    DRV_SURGE, DRV_NOISE, DRV_ALL_SHAKE
  } drive_mode_e;

  // result-side stall styles
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_style_e;

  // plausibility predictor and the queue of verdicts still owed by the block
  class plausibility_scoreboard;
    logic [14:0] speed_max, jump_limit, speed_step, brake_step;
    logic [15:0] recovery_len;
    logic signed [15:0] prev_speed, prev_brake;
    logic prev_speed_bad, prev_brake_bad;
    logic signed [16:0] prev_speed_dlt, prev_brake_dlt;
    logic prev_speed_dlt_undef, prev_brake_dlt_undef;
    logic [7:0] speed_rev_cnt, brake_rev_cnt, key_chg_cnt, prev_key;
    logic [15:0] good_run;
    verdict_t verdict_q[$];
    int unsigned samples_seen, verdicts_checked, mismatches;
    logic [13:0] faults_seen;

    function new();
      speed_max = 15'd25000;
      jump_limit = 15'd2000;
      speed_step = 15'd200;
      brake_step = 15'd500;
      recovery_len = 16'd10;
      prev_speed = '0;
      prev_brake = '0;
      prev_speed_bad = 1'b0;
      prev_brake_bad = 1'b0;
      prev_speed_dlt = '0;
      prev_brake_dlt = '0;
      prev_speed_dlt_undef = 1'b0;
      prev_brake_dlt_undef = 1'b0;
      speed_rev_cnt = '0;
      brake_rev_cnt = '0;
      key_chg_cnt = '0;
      prev_key = IgnOff;
      good_run = 16'd10;
      samples_seen = 0;
      verdicts_checked = 0;
      mismatches = 0;
      faults_seen = '0;
    endfunction

    // register write as the block sees it, masked to the register width
    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        CFG_SPEED_MAX:         speed_max = val[14:0];
        CFG_SPEED_JUMP_LIMIT:  jump_limit = val[14:0];
        CFG_SPEED_JITTER_STEP: speed_step = val[14:0];
        CFG_BRAKE_JITTER_STEP: brake_step = val[14:0];
        CFG_RECOVERY_CYCLES:   recovery_len = val;
        default: ;
      endcase
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function logic [7:0] bump(logic [7:0] c);
      return (c == 8'hFF) ? c : c + 8'd1;
    endfunction

    // opposite-sign steps above the threshold count up, same-sign steps clear
    function logic [7:0] reversal_next(logic [7:0] cnt, bit fin, int d, bit du,
                                       int pd, bit pdu, int step);
      if (fin && !du && !pdu && magnitude(d) > step && magnitude(pd) > step)
        return ((d < 0) != (pd < 0)) ? bump(cnt) : 8'd0;
      return cnt;
    endfunction

    // work out the verdict of an accepted sample set and queue it
    function void note_sample(sample_t s);
      verdict_t v;
      int spd, brk, sd, bd;
      bit spd_fin, brk_fin, sd_undef, bd_undef, spd_range, brk_range, no_jump;
      bit spd_calm, brk_calm, key_range, key_calm, all_good;
      v = '0;
      spd = s.speed;
      brk = s.brake;
      spd_fin = !s.speed_bad;
      brk_fin = !s.brake_bad;

      // speed
      sd_undef = !spd_fin || prev_speed_bad;
      sd = sd_undef ? 0 : spd - int'(prev_speed);
      spd_range = spd_fin && spd >= 0 && spd <= int'(speed_max);
      v.fault[FltSpeedBad] = !spd_fin;
      v.fault[FltSpeedRange] = spd_fin && !spd_range;
      no_jump = !spd_fin || (!sd_undef && magnitude(sd) <= int'(jump_limit));
      v.fault[FltSpeedJump] = !no_jump;
      speed_rev_cnt = reversal_next(speed_rev_cnt, spd_fin, sd, sd_undef,
                                    int'(prev_speed_dlt), prev_speed_dlt_undef,
                                    int'(speed_step));
      spd_calm = speed_rev_cnt < ReversalTrip;
      v.fault[FltSpeedJitter] = !spd_calm;
      v.fault[FltSpeedIgnOff] = spd_fin && spd > CreepSpeed && s.ignition == IgnOff;
      prev_speed_dlt = 17'(sd);
      prev_speed_dlt_undef = sd_undef;
      prev_speed = s.speed;
      prev_speed_bad = s.speed_bad;
      v.speed_ok = spd_range && no_jump && spd_calm;

      // ignition
      key_range = s.ignition <= IgnStart;
      key_chg_cnt = (s.ignition != prev_key) ? bump(key_chg_cnt) : 8'd0;
      key_calm = key_chg_cnt < ChangeTrip;
      v.fault[FltIgnRange] = !key_range;
      v.fault[FltIgnChatter] = !key_calm;
      v.fault[FltIgnSkip] = key_range && prev_key == IgnOff && s.ignition >= IgnOn;
      prev_key = s.ignition;
      v.ignition_ok = key_range && key_calm;

      // brake
      bd_undef = !brk_fin || prev_brake_bad;
      bd = bd_undef ? 0 : brk - int'(prev_brake);
      brk_range = brk_fin && brk >= 0 && brk <= PedalFull;
      v.fault[FltBrakeBad] = !brk_fin;
      v.fault[FltBrakeRange] = brk_fin && !brk_range;
      brake_rev_cnt = reversal_next(brake_rev_cnt, brk_fin, bd, bd_undef,
                                    int'(prev_brake_dlt), prev_brake_dlt_undef,
                                    int'(brake_step));
      brk_calm = brake_rev_cnt < ReversalTrip;
      v.fault[FltBrakeJitter] = !brk_calm;
      v.fault[FltBrakeSurge] = brk_fin && brk >= PedalHard && !sd_undef && sd > SurgeDelta;
      prev_brake_dlt = 17'(bd);
      prev_brake_dlt_undef = bd_undef;
      prev_brake = s.brake;
      prev_brake_bad = s.brake_bad;
      v.brake_ok = brk_range && brk_calm;

      // composite valid behind the recovery run
      all_good = v.speed_ok && v.ignition_ok && v.brake_ok;
      if (all_good) begin
        if (good_run < recovery_len) good_run++;
      end else begin
        good_run = '0;
      end
      v.fault[FltRecovery] = all_good && good_run < recovery_len;
      v.composite_ok = good_run >= recovery_len;

      verdict_q.push_back(v);
      samples_seen++;
    endfunction

    function void compare_field(string name, logic [13:0] want, logic [13:0] got);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      end
    endfunction

    // compare one accepted result word with the oldest owed verdict
    function void check_verdict(logic [OutDataW-1:0] word);
      verdict_t got, want;
      got = verdict_t'(word[17:0]);
      verdicts_checked++;
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportCap)
          $display("%0t: result %h with no sample set owed, expected none", $time, word);
        return;
      end
      want = verdict_q.pop_front();
      faults_seen |= got.fault;
      compare_field("fault_code", want.fault, got.fault);
      compare_field("speed_ok", 14'(want.speed_ok), 14'(got.speed_ok));
      compare_field("ignition_ok", 14'(want.ignition_ok), 14'(got.ignition_ok));
      compare_field("brake_ok", 14'(want.brake_ok), 14'(got.brake_ok));
      compare_field("composite_ok", 14'(want.composite_ok), 14'(got.composite_ok));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgDataW-1:0]  cfg_wdata_i;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  // speed[15:0], speed_bad[16], ignition[24:17], brake[40:25], brake_bad[41], zero fill
  logic [InDataW-1:0]   s_axis_tdata_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  // fault_code[13:0], speed_ok[14], ignition_ok[15], brake_ok[16], composite_ok[17],
  // zero fill
  logic [OutDataW-1:0]  m_axis_tdata_o;

  plausibility_scoreboard sb = new();

  // trajectory of the well-formed stimulus
  int road_speed = 0;
  int pedal = 0;
  logic [7:0] key_pos = IgnOff;
  bit flip = 1'b0;
  int burst_left = 0;
  int phases = 1;
  bit hold_req = 1'b0;

  powertrain_signal_plausibility dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic sample_t sample_of(int spd, bit sbad, logic [7:0] key, int brk,
                                        bit bbad);
    sample_t s;
    s.speed = 16'(spd);
    s.speed_bad = sbad;
    s.ignition = key;
    s.brake = 16'(brk);
    s.brake_bad = bbad;
    return s;
  endfunction

  // next sample set of the given shape, built on a slowly drifting drive
  function automatic sample_t next_sample(drive_mode_e m);
    sample_t s;
    int amp;
    flip = !flip;
    road_speed = clamp(road_speed + int'($urandom_range(0, 600)) - 300, 0, 24000);
    pedal = clamp(pedal + int'($urandom_range(0, 800)) - 400, 0, PedalFull);
    // key moves off, acc, on and toggles to start now and then
    if ($urandom_range(0, 24) == 0)
      key_pos = (key_pos == IgnOn) ? IgnStart : (key_pos == IgnStart) ? IgnOn :
                key_pos + 8'd1;
    if ($urandom_range(0, 99) == 0) key_pos = IgnOff;
    s = sample_of(road_speed, $urandom_range(0, 49) == 0, key_pos, pedal,
                  $urandom_range(0, 49) == 0);
    if (m == DRV_SPEED_SHAKE || m == DRV_ALL_SHAKE) begin
      amp = int'(sb.speed_step) / 2 + int'($urandom_range(1, 400));
      s.speed = 16'(flip ? road_speed + amp : road_speed - amp);
      s.speed_bad = 1'b0;
    end
    if (m == DRV_BRAKE_SHAKE || m == DRV_ALL_SHAKE) begin
      amp = int'(sb.brake_step) / 2 + int'($urandom_range(1, 400));
      s.brake = 16'(flip ? 5000 + amp : 5000 - amp);
      s.brake_bad = 1'b0;
    end
    if (m == DRV_IGN_CHATTER || m == DRV_ALL_SHAKE) begin
      key_pos = 8'((int'(key_pos) + int'($urandom_range(1, 3))) % (int'(IgnStart) + 1));
      s.ignition = key_pos;
    end
    if (m == DRV_SURGE) begin
      road_speed += int'($urandom_range(1001, 1800));
      pedal = int'($urandom_range(PedalHard, PedalFull));
      s = sample_of(road_speed, 1'b0, key_pos, pedal, 1'b0);
    end
    if (m == DRV_NOISE)
      s = sample_of(int'($urandom), 1'($urandom), 8'($urandom), int'($urandom),
                    1'($urandom));
    return s;
  endfunction

  // offer one sample set and hold it until the block takes it
  task automatic send_sample(sample_t s);
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {6'b0, s.brake_bad, s.brake, s.ignition, s.speed_bad, s.speed};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_sample(s);
  endtask

  // sender gap with junk on the data lines
  task automatic idle_sender(int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i <= InDataW'({$urandom, $urandom});
    end
  endtask

  // n sample sets of one shape, paced in bursts
  task automatic run_mode(drive_mode_e m, int n);
    repeat (n) begin
      if (burst_left == 0) begin
        idle_sender(($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) :
                    $urandom_range(1, 4));
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_sample(next_sample(m));
    end
  endtask

  // random mix of shapes in segments
  task automatic run_random(int n);
    int pick, len;
    drive_mode_e m;
    while (n > 0) begin
      pick = $urandom_range(0, 99);
      m = (pick < 35) ? DRV_CRUISE : (pick < 47) ? DRV_SPEED_SHAKE :
          (pick < 59) ? DRV_BRAKE_SHAKE : (pick < 67) ? DRV_IGN_CHATTER :
          (pick < 75) ? DRV_SURGE : (pick < 90) ? DRV_NOISE : DRV_ALL_SHAKE;
      len = clamp($urandom_range(4, 25), 1, n);
      run_mode(m, len);
      n -= len;
    end
  endtask

  // stop offering and wait until every owed verdict has come back
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
  endtask

  // new settings on an idle block; top bit of the 15-bit registers is junk
  task automatic apply_settings(int smax, int jump, int sstep, int bstep, int rlen);
    drain();
    write_reg(CFG_SPEED_MAX, {1'($urandom), 15'(smax)});
    write_reg(CFG_SPEED_JUMP_LIMIT, {1'($urandom), 15'(jump)});
    write_reg(CFG_SPEED_JITTER_STEP, {1'($urandom), 15'(sstep)});
    write_reg(CFG_BRAKE_JITTER_STEP, {1'($urandom), 15'(bstep)});
    write_reg(CFG_RECOVERY_CYCLES, 16'(rlen));
    // unmapped index must leave every register alone
    write_reg(CfgIdxW'(CFG_RECOVERY_CYCLES) + CfgIdxW'($urandom_range(1, 3)),
              16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    phases++;
  endtask

  // result side: stall styles in stretches plus a long requested hold-off
  initial begin
    int left, beat, hold_left;
    rx_style_e style;
    m_axis_tready_i = 1'b0;
    left = 0;
    beat = 0;
    hold_left = 0;
    style = RX_OPEN;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        if (left == 0) begin
          style = rx_style_e'($urandom_range(0, 3));
          left = $urandom_range(10, 80);
        end
        left--;
        beat++;
        case (style)
          RX_OPEN:   m_axis_tready_i <= 1'b1;
          RX_COIN:   m_axis_tready_i <= 1'($urandom);
          RX_SPARSE: m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default:   m_axis_tready_i <= (beat % 3 != 0);
        endcase
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_verdict(m_axis_tdata_o);
  end

  // watchdog on cycles without any transfer
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, StallLimit);
    $display("FAIL powertrain_signal_plausibility");
    $finish;
  end

  // main sequence
  initial begin
    sample_t opening[$];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed sets under the reset settings
    opening.push_back(sample_of(0, 0, IgnOff, 0, 0));
    opening.push_back(sample_of(100, 0, KeyAcc, 0, 0));
    opening.push_back(sample_of(300, 0, IgnOn, 100, 0));
    opening.push_back(sample_of(25000, 0, IgnOn, 100, 0));      // jump up to the top
    opening.push_back(sample_of(25001, 0, IgnOn, 100, 0));      // just over the top
    opening.push_back(sample_of(-32768, 0, IgnOn, -32768, 0));  // most negative
    opening.push_back(sample_of(32767, 0, IgnOn, 32767, 0));    // most positive
    opening.push_back(sample_of(1234, 1, IgnOn, 5000, 0));      // speed not finite
    opening.push_back(sample_of(1000, 0, IgnOn, 5000, 0));      // delta undefined
    opening.push_back(sample_of(2200, 0, IgnOn, 9600, 0));      // hard brake while surging
    opening.push_back(sample_of(2200, 0, IgnOn, -1, 1));        // brake not finite
    opening.push_back(sample_of(2200, 0, IgnOn, PedalFull, 0));
    opening.push_back(sample_of(2200, 0, IgnOn, PedalFull + 1, 0));
    opening.push_back(sample_of(2200, 0, IgnStart + 8'd1, 5000, 0));
    opening.push_back(sample_of(2200, 0, 8'hFF, 5000, 0));
    opening.push_back(sample_of(600, 0, IgnOff, 5000, 0));      // moving with key off
    opening.push_back(sample_of(0, 0, IgnStart, 5000, 0));      // acc skipped
    opening.push_back(sample_of(0, 0, IgnOff, 0, 0));           // key chatter run
    opening.push_back(sample_of(0, 0, KeyAcc, 0, 0));
    opening.push_back(sample_of(0, 0, IgnOff, 0, 0));
    opening.push_back(sample_of(0, 0, KeyAcc, 0, 0));
    opening.push_back(sample_of(0, 0, IgnOff, 0, 0));
    opening.push_back(sample_of(0, 0, IgnOff, 0, 0));
    opening.push_back(sample_of(0, 0, KeyAcc, 0, 0));
    foreach (opening[i]) send_sample(opening[i]);

    // long hold-off on the result side while every signal shakes until the
    // reversal and change counters sit at their ceiling
    hold_req = 1'b1;
    burst_left = 60;
    run_mode(DRV_ALL_SHAKE, 265);
    run_mode(DRV_CRUISE, 30);

    // extremes first, then ordinary and random settings
    apply_settings(32767, 32767, 0, 0, 1);
    run_random(50);
    apply_settings(0, 0, 32767, 32767, 0);
    run_random(40);
    apply_settings(25000, 2000, 200, 500, 65535);
    run_random(30);
    apply_settings($urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(0, 32767), $urandom_range(0, 32767),
                   $urandom_range(1, 20));
    run_random(50);
    apply_settings(12000, 500, 100, 300, 3);
    run_random(50);
    apply_settings($urandom_range(10000, 32767), $urandom_range(500, 4000),
                   $urandom_range(0, 400), $urandom_range(0, 800),
                   $urandom_range(1, 20));
    run_random(50);

    // wind down
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.verdict_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run covered %0d sample sets and %0d results over %0d setting phases",
             sb.samples_seen, sb.verdicts_checked, phases);
    $display("fault bits raised at least once: %b, mismatches: %0d",
             sb.faults_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.verdict_q.size() == 0) begin
      $display("PASS powertrain_signal_plausibility");
    end else begin
      $display("%0d results still owed at the end", sb.verdict_q.size());
      $display("FAIL powertrain_signal_plausibility");
    end
    $finish;
  end

endmodule
